### src/ilst_pkg.sv
// Shared types, codes and constants of the indexed list store.
`default_nettype none

package ilst_pkg;

    localparam int CAPACITY_DEF = 16;
    localparam int OP_W         = 3;
    localparam int POS_W        = 4;
    localparam int VAL_W        = 32;
    localparam int STAT_W       = 2;
    localparam int CNT_OUT_W    = 5;

    typedef enum logic [OP_W-1:0] {
        OP_APPEND = 3'd0,
        OP_INSERT = 3'd1,
        OP_ERASE  = 3'd2,
        OP_FIND   = 3'd3,
        OP_READ   = 3'd4
    } t_op;

    typedef enum logic [STAT_W-1:0] {
        ST_OK      = 2'd0,
        ST_RANGE   = 2'd1,
        ST_FULL    = 2'd2,
        ST_MISSING = 2'd3
    } t_status;

    // What every cell does with its entry in this cycle.
    typedef enum logic [1:0] {
        CK_NONE   = 2'd0,
        CK_APPEND = 2'd1,
        CK_INSERT = 2'd2,
        CK_ERASE  = 2'd3
    } t_kind;

    typedef struct packed {
        t_kind                   kind;
        logic [POS_W-1:0]        pos;
        logic signed [VAL_W-1:0] value;
    } t_cmd;

    // Search token that walks the chain, carrying the last hit so far.
    typedef struct packed {
        logic             vld;
        logic             hit;
        logic [POS_W-1:0] idx;
    } t_tok;

    typedef struct packed {
        t_status                 status;
        logic [POS_W-1:0]        pos;
        logic signed [VAL_W-1:0] value;
        logic [CNT_OUT_W-1:0]    count;
    } t_res;

endpackage

`default_nettype wire

### src/ilst_cell.sv
// One storage cell of the list: holds one entry, shifts with its neighbors, checks search tokens.
`default_nettype none

module ilst_cell #(
    parameter int CAPACITY = ilst_pkg::CAPACITY_DEF,
    parameter int IDX      = 0
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire ilst_pkg::t_cmd                     i_cmd,
    input  wire logic [$clog2(CAPACITY+1)-1:0]      i_count,
    input  wire logic signed [ilst_pkg::VAL_W-1:0]  i_left_data,
    input  wire logic signed [ilst_pkg::VAL_W-1:0]  i_right_data,
    output logic signed [ilst_pkg::VAL_W-1:0]       o_data,
    input  wire ilst_pkg::t_tok                     i_tok,
    output ilst_pkg::t_tok                          o_tok
);

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int EW    = (CNT_W > ilst_pkg::CNT_OUT_W) ? CNT_W : ilst_pkg::CNT_OUT_W;
    localparam logic [EW-1:0] MY_IDX = EW'(IDX);

    logic signed [ilst_pkg::VAL_W-1:0] r_data;
    logic signed [ilst_pkg::VAL_W-1:0] n_data;
    ilst_pkg::t_tok                    r_tok;
    ilst_pkg::t_tok                    n_tok;
    logic [EW-1:0]                     w_pos;
    logic [EW-1:0]                     w_cnt;
    logic                              w_in_use;

    assign w_pos    = EW'(i_cmd.pos);
    assign w_cnt    = EW'(i_count);
    assign w_in_use = MY_IDX < w_cnt;

    always_comb begin
        n_data = r_data;
        case (i_cmd.kind)
            ilst_pkg::CK_APPEND: begin
                if (MY_IDX == w_cnt) begin
                    n_data = i_cmd.value;
                end
            end
            ilst_pkg::CK_INSERT: begin
                if (MY_IDX == w_pos) begin
                    n_data = i_cmd.value;
                end else if (MY_IDX > w_pos) begin
                    n_data = i_left_data;
                end
            end
            ilst_pkg::CK_ERASE: begin
                if (MY_IDX >= w_pos) begin
                    n_data = i_right_data;
                end
            end
            default: begin
                n_data = r_data;
            end
        endcase
    end

    // Pass the token on; a valid entry equal to the key takes over the hit.
    always_comb begin
        n_tok = i_tok;
        if (i_tok.vld && w_in_use && (r_data == i_cmd.value)) begin
            n_tok.hit = 1'b1;
            n_tok.idx = MY_IDX[ilst_pkg::POS_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok <= '0;
        end else begin
            r_tok <= n_tok;
        end
    end

    assign o_data = r_data;
    assign o_tok  = r_tok;

endmodule

`default_nettype wire

### src/indexed_list_store.sv
// Top level of the indexed list store: op decode, entry count, cell chain and result staging.
//
//  channel | direction | handshake                    | payload
//  --------+-----------+------------------------------+-----------------------------------------
//  in      | to block  | i_in_valid / o_in_stall      | i_op, i_position, i_item_value
//  out     | from block| o_out_valid / i_out_stall    | o_status, o_found_position,
//          |           |                              | o_read_value, o_entry_count
//
// Append, insert, erase, read and unused codes finish at the accepting edge: the cells shift in
// place and, if the output is free, a new transaction can follow in the next cycle.
// Find: a search token walks the chain of cells one cell per cycle.
// A result that cannot leave waits in a pending register; the input stalls only while a
// search runs or a result is pending. Reset is synchronous and clears count, FSM and tokens.
// Entries themselves are not reset.
`default_nettype none

module indexed_list_store #(
    parameter int CAPACITY = ilst_pkg::CAPACITY_DEF
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_in_valid,
    output logic                                     o_in_stall,
    input  wire logic [ilst_pkg::OP_W-1:0]           i_op,
    input  wire logic [ilst_pkg::POS_W-1:0]          i_position,
    input  wire logic signed [ilst_pkg::VAL_W-1:0]   i_item_value,
    output logic                                     o_out_valid,
    input  wire logic                                i_out_stall,
    output logic [ilst_pkg::STAT_W-1:0]              o_status,
    output logic [ilst_pkg::POS_W-1:0]               o_found_position,
    output logic signed [ilst_pkg::VAL_W-1:0]        o_read_value,
    output logic [ilst_pkg::CNT_OUT_W-1:0]           o_entry_count
);

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int EW    = (CNT_W > ilst_pkg::CNT_OUT_W) ? CNT_W : ilst_pkg::CNT_OUT_W;
    // Positions only reach the first sixteen cells, so a read selects among those.
    localparam int RD_N  = (CAPACITY < 16) ? CAPACITY : 16;
    localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_SEARCH = 3'b010,
        S_HOLD   = 3'b100
    } t_state;

    t_state                            r_state;
    t_state                            n_state;
    logic [CNT_W-1:0]                  r_count;
    logic [CNT_W-1:0]                  n_count;
    logic signed [ilst_pkg::VAL_W-1:0] r_key;
    logic signed [ilst_pkg::VAL_W-1:0] n_key;
    logic                              r_out_valid;
    logic                              n_out_valid;
    ilst_pkg::t_res                    r_out;
    ilst_pkg::t_res                    n_out;
    ilst_pkg::t_res                    r_pend;
    ilst_pkg::t_res                    n_pend;

    logic                              w_accept;
    logic                              w_out_free;
    logic                              w_full;
    logic [EW-1:0]                     w_pos_x;
    logic [EW-1:0]                     w_cnt_x;
    logic [EW-1:0]                     w_new_cnt_x;
    logic signed [ilst_pkg::VAL_W-1:0] w_rd;
    ilst_pkg::t_res                    w_res;
    ilst_pkg::t_res                    w_find_res;
    ilst_pkg::t_cmd                    w_cmd;
    logic                              w_find_start;

    logic signed [ilst_pkg::VAL_W-1:0] w_data [CAPACITY];
    ilst_pkg::t_tok                    w_tok  [CAPACITY+1];

    assign o_in_stall = (r_state != S_IDLE);
    assign w_accept   = i_in_valid && (r_state == S_IDLE);
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_full     = (r_count == CAP_CNT);
    assign w_pos_x    = EW'(i_position);
    assign w_cnt_x    = EW'(r_count);

    // Read select over the cells a position can name.
    always_comb begin
        w_rd = '0;
        for (int j = 0; j < RD_N; j++) begin
            if (i_position == ilst_pkg::POS_W'(j)) begin
                w_rd = w_data[j];
            end
        end
    end

    // Decode the op: status, cell command, search start and count of a transaction.
    always_comb begin
        w_res.status  = ilst_pkg::ST_OK;
        w_res.pos     = i_position;
        w_res.value   = '0;
        w_cmd.kind    = ilst_pkg::CK_NONE;
        w_cmd.pos     = i_position;
        w_cmd.value   = w_accept ? i_item_value : r_key;
        w_find_start  = 1'b0;
        n_count       = r_count;
        case (ilst_pkg::t_op'(i_op))
            ilst_pkg::OP_APPEND: begin
                if (w_full) begin
                    w_res.status = ilst_pkg::ST_FULL;
                    w_res.pos    = '0;
                end else begin
                    w_res.pos  = w_cnt_x[ilst_pkg::POS_W-1:0];
                    w_cmd.kind = ilst_pkg::CK_APPEND;
                    n_count    = r_count + CNT_W'(1);
                end
            end
            ilst_pkg::OP_INSERT: begin
                if (w_pos_x > w_cnt_x) begin
                    w_res.status = ilst_pkg::ST_RANGE;
                end else if (w_full) begin
                    w_res.status = ilst_pkg::ST_FULL;
                end else begin
                    w_cmd.kind = ilst_pkg::CK_INSERT;
                    n_count    = r_count + CNT_W'(1);
                end
            end
            ilst_pkg::OP_ERASE: begin
                if (w_pos_x >= w_cnt_x) begin
                    w_res.status = ilst_pkg::ST_RANGE;
                end else begin
                    w_cmd.kind = ilst_pkg::CK_ERASE;
                    n_count    = r_count - CNT_W'(1);
                end
            end
            ilst_pkg::OP_FIND: begin
                w_find_start = 1'b1;
            end
            ilst_pkg::OP_READ: begin
                if (w_pos_x >= w_cnt_x) begin
                    w_res.status = ilst_pkg::ST_RANGE;
                end else begin
                    w_res.value = w_rd;
                end
            end
            default: begin
                w_res.status = ilst_pkg::ST_RANGE;
            end
        endcase
        // Cells and count move only on an accepted transaction.
        if (!w_accept) begin
            w_cmd.kind   = ilst_pkg::CK_NONE;
            w_find_start = 1'b0;
            n_count      = r_count;
        end
        w_new_cnt_x = EW'(n_count);
        w_res.count = w_new_cnt_x[ilst_pkg::CNT_OUT_W-1:0];
    end

    // Inject the search token into the first cell on an accepted find.
    assign w_tok[0] = {w_find_start, 1'b0, {ilst_pkg::POS_W{1'b0}}};

    // Result of a finished search, taken from the token leaving the last cell.
    always_comb begin
        w_find_res.status = w_tok[CAPACITY].hit ? ilst_pkg::ST_OK : ilst_pkg::ST_MISSING;
        w_find_res.pos    = w_tok[CAPACITY].hit ? w_tok[CAPACITY].idx : '0;
        w_find_res.value  = '0;
        w_find_res.count  = w_cnt_x[ilst_pkg::CNT_OUT_W-1:0];
    end

    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++) begin : g_cell
            logic signed [ilst_pkg::VAL_W-1:0] w_left;
            logic signed [ilst_pkg::VAL_W-1:0] w_right;
            if (g == 0) begin : g_first
                assign w_left = w_cmd.value;
            end else begin : g_mid_l
                assign w_left = w_data[g-1];
            end
            if (g == CAPACITY - 1) begin : g_last
                assign w_right = w_data[g];
            end else begin : g_mid_r
                assign w_right = w_data[g+1];
            end
            ilst_cell #(
                .CAPACITY (CAPACITY),
                .IDX      (g)
            ) u_cell (
                .i_clk        (i_clk),
                .i_rst_n      (i_rst_n),
                .i_cmd        (w_cmd),
                .i_count      (r_count),
                .i_left_data  (w_left),
                .i_right_data (w_right),
                .o_data       (w_data[g]),
                .i_tok        (w_tok[g]),
                .o_tok        (w_tok[g+1])
            );
        end
    endgenerate

    // Sequence: accept, run a search, hold a result that cannot leave yet.
    always_comb begin
        n_state     = r_state;
        n_key       = r_key;
        n_out       = r_out;
        n_pend      = r_pend;
        n_out_valid = r_out_valid && i_out_stall;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    if (w_find_start) begin
                        n_key   = i_item_value;
                        n_state = S_SEARCH;
                    end else if (w_out_free) begin
                        n_out       = w_res;
                        n_out_valid = 1'b1;
                    end else begin
                        n_pend  = w_res;
                        n_state = S_HOLD;
                    end
                end
            end
            S_SEARCH: begin
                if (w_tok[CAPACITY].vld) begin
                    if (w_out_free) begin
                        n_out       = w_find_res;
                        n_out_valid = 1'b1;
                        n_state     = S_IDLE;
                    end else begin
                        n_pend  = w_find_res;
                        n_state = S_HOLD;
                    end
                end
            end
            S_HOLD: begin
                if (w_out_free) begin
                    n_out       = r_pend;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key  <= n_key;
        r_out  <= n_out;
        r_pend <= n_pend;
    end

    assign o_out_valid      = r_out_valid;
    assign o_status         = r_out.status;
    assign o_found_position = r_out.pos;
    assign o_read_value     = r_out.value;
    assign o_entry_count    = r_out.count;

endmodule

`default_nettype wire

### src/ilst_chk.sv
// Port-level checker for the indexed list store, bound to the top level.
`default_nettype none

module ilst_chk (
    input wire logic                                i_clk,
    input wire logic                                i_rst_n,
    input wire logic                                i_out_stall,
    input wire logic                                o_out_valid,
    input wire logic [ilst_pkg::STAT_W-1:0]         o_status,
    input wire logic [ilst_pkg::POS_W-1:0]          o_found_position,
    input wire logic signed [ilst_pkg::VAL_W-1:0]   o_read_value,
    input wire logic [ilst_pkg::CNT_OUT_W-1:0]      o_entry_count
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> $stable(o_status) && $stable(o_found_position)
            && $stable(o_read_value) && $stable(o_entry_count))
        else $error("result changed while stalled");

    a_fail_no_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status != ilst_pkg::ST_OK) |-> (o_read_value == '0))
        else $error("failed transaction carries a read value");

    a_missing_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status == ilst_pkg::ST_MISSING) |-> (o_found_position == '0))
        else $error("missed search reports a position");

endmodule

bind indexed_list_store ilst_chk u_ilst_chk (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_out_stall      (i_out_stall),
    .o_out_valid      (o_out_valid),
    .o_status         (o_status),
    .o_found_position (o_found_position),
    .o_read_value     (o_read_value),
    .o_entry_count    (o_entry_count)
);

`default_nettype wire
